FILE: design/mpdq_pkg.sv
// Shared types, constants and helpers for the mouse packet decoder queue.
package mpdq_pkg;

   // Event queue geometry (the ring holds one fewer event than its depth)
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Request opcodes
   localparam logic OP_RX_BYTE = 1'b0;
   localparam logic OP_POP     = 1'b1;

   // Packet framing
   localparam int   SYNC_BIT   = 3;     // bit that marks a first packet byte
   localparam logic [1:0] LAST_POS_STD   = 2'd2;
   localparam logic [1:0] LAST_POS_WHEEL = 2'd3;

   typedef logic [PTR_W-1:0] ptr_type;

   // One decoded event as stored in the queue (23 bits)
   typedef struct packed {
      logic signed [3:0] wheel;
      logic signed [7:0] move_y;
      logic signed [7:0] move_x;
      logic        [2:0] buttons;
   } event_type;

   // Push from the assembler to the queue
   typedef struct packed {
      logic      valid;
      event_type evt;
   } push_type;

   // Ring pointer advance with wrap at the queue depth
   function automatic ptr_type next_ptr(input ptr_type p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

FILE: design/mpdq_intf.sv
// Channel interfaces: request, response and configuration write.

interface mpdq_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface mpdq_rsp_if;
   logic              valid;
   logic              ready;
   logic              got_event;
   logic        [2:0] buttons;
   logic signed [7:0] move_x;
   logic signed [7:0] move_y;
   logic signed [3:0] wheel;
   modport source (output valid, output got_event, output buttons, output move_x,
                   output move_y, output wheel, input ready);
   modport sink   (input valid, input got_event, input buttons, input move_x,
                   input move_y, input wheel, output ready);
endinterface

interface mpdq_csr_if;
   logic valid;
   logic ready;
   logic wheel_mode;
   modport source (output valid, output wheel_mode, input ready);
   modport sink   (input valid, input wheel_mode, output ready);
endinterface

FILE: design/mpdq_assembler.sv
// Packet assembler: frames received bytes into packets and decodes events.
module mpdq_assembler
   import mpdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wheel_mode,
   input  logic       byte_valid,
   input  logic [7:0] rx_byte,
   output push_type   push
);

   logic       wheel_mode_ff, wheel_mode_in;
   logic [1:0] pos_ff, pos_in;
   logic [7:0] pkt_ff [3];
   logic [1:0] last_pos;
   logic       drop;
   logic       complete;
   logic [7:0] b0, b1, b2;

   // Mode register
   assign wheel_mode_in = csr_we ? csr_wheel_mode : wheel_mode_ff;

   // Framing: skip bytes until a sync byte, finish at the last position
   assign last_pos = wheel_mode_ff ? LAST_POS_WHEEL : LAST_POS_STD;
   assign drop     = (pos_ff == 2'd0) && !rx_byte[SYNC_BIT];
   assign complete = byte_valid && !drop && (pos_ff >= last_pos);

   always_comb begin
      pos_in = pos_ff;
      if (byte_valid && !drop) begin
         pos_in = complete ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_mode_ff <= 1'b0;
         pos_ff        <= 2'd0;
      end else begin
         wheel_mode_ff <= wheel_mode_in;
         pos_ff        <= pos_in;
      end
   end

   // Packet byte capture
   always_ff @(posedge clock) begin
      if (byte_valid && !drop && pos_ff != 2'd3) begin
         pkt_ff[pos_ff] <= rx_byte;
      end
   end

   // Bypass the byte arriving in the completing cycle
   assign b0 = pkt_ff[0];
   assign b1 = pkt_ff[1];
   assign b2 = (pos_ff == 2'd2) ? rx_byte : pkt_ff[2];

   always_comb begin
      push.valid       = complete;
      push.evt.buttons = b0[2:0];
      push.evt.move_x  = b1;
      push.evt.move_y  = b2;
      push.evt.wheel   = wheel_mode_ff ? rx_byte[3:0] : 4'd0;
   end

endmodule

FILE: design/mpdq_queue.sv
// Event ring queue: one synchronous memory with read and write pointers.
module mpdq_queue
   import mpdq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop_req,
   output logic      pop_hit,
   output event_type rd_data
);

   event_type mem [QUEUE_DEPTH];
   ptr_type   rd_ptr_ff, rd_ptr_in;
   ptr_type   wr_ptr_ff, wr_ptr_in;
   logic      full;
   logic      do_write;
   logic      do_read;

   // Occupancy
   assign full     = (next_ptr(wr_ptr_ff) == rd_ptr_ff);
   assign pop_hit  = (rd_ptr_ff != wr_ptr_ff);
   assign do_write = push.valid && !full;
   assign do_read  = pop_req && pop_hit;

   assign wr_ptr_in = do_write ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = do_read  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Storage; read data holds until the next read
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= push.evt;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_data <= mem[rd_ptr_ff];
      end
   end

endmodule

FILE: design/mouse_packet_decoder_queue_top.sv
// Top level of the mouse packet decoder queue.
//
// Accepts one request per cycle: a received aux byte (op 0) or a pop (op 1).
// Bytes are framed into 3-byte packets, or 4-byte packets in wheel mode, after
// a first byte with bit 3 set; each packet becomes an event pushed into a
// 32-entry ring memory holding up to 31 events (extra events are dropped).
// Each pop returns one response, passed through the synchronous memory read and
// then the output register; got_event is 0 with all fields zero when the queue
// is empty. Pops and bytes stream at one request per cycle while the response
// side keeps up; byte requests produce no response. The wheel_mode register is
// written through the csr channel, which is always ready, and should only be
// written while the block is idle.
module mouse_packet_decoder_queue_top
   import mpdq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mpdq_req_if.sink   req,
   mpdq_rsp_if.source rsp,
   mpdq_csr_if.sink   csr
);

   push_type  push;
   event_type rd_data;
   logic      pop_hit;
   logic      req_acc;
   logic      byte_valid;
   logic      pop_req;
   logic      out_free;
   logic      move;
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_hit_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      got_ff;
   event_type evt_ff;

   // Request decode
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_acc    = req.valid && req.ready;
   assign byte_valid = req_acc && (req.op == OP_RX_BYTE);
   assign pop_req    = req_acc && (req.op == OP_POP);
   assign csr.ready  = 1'b1;

   mpdq_assembler u_asm (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr.valid && csr.ready),
      .csr_wheel_mode (csr.wheel_mode),
      .byte_valid     (byte_valid),
      .rx_byte        (req.rx_byte),
      .push           (push)
   );

   mpdq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop_req (pop_req),
      .pop_hit (pop_hit),
      .rd_data (rd_data)
   );

   // Read stage: waits for memory data, holds while the output is blocked
   assign move         = s1_valid_ff && out_free;
   assign s1_valid_in  = pop_req || (s1_valid_ff && !out_free);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_req) begin
         s1_hit_ff <= pop_hit;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (move) begin
         got_ff <= s1_hit_ff;
         evt_ff <= s1_hit_ff ? rd_data : '0;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.got_event = got_ff;
   assign rsp.buttons   = evt_ff.buttons;
   assign rsp.move_x    = evt_ff.move_x;
   assign rsp.move_y    = evt_ff.move_y;
   assign rsp.wheel     = evt_ff.wheel;

endmodule
